FILE: hdl/m3inv_pkg.sv
// ----------------------------------------------------------------------------
// m3inv_pkg
// shared types, constants and helpers for the 3x3 inverse datapath
// ----------------------------------------------------------------------------
package m3inv_pkg;

    localparam int N_ENT    = 9;   // entries of a 3x3 matrix
    localparam int F_STAGES = 8;   // front pipeline depth
    localparam int QBITS    = 33;  // quotient bits resolved by the divider
    localparam int Q_DEPTH  = 4;   // default queue depth

    // adjugate entry k = a[idx0]*a[idx1] - a[idx2]*a[idx3], row-major indexes
    localparam logic [3:0] MINOR_IDX [0:8][0:3] = '{
        '{4'd4, 4'd8, 4'd5, 4'd7},
        '{4'd2, 4'd7, 4'd1, 4'd8},
        '{4'd1, 4'd5, 4'd2, 4'd4},
        '{4'd5, 4'd6, 4'd3, 4'd8},
        '{4'd0, 4'd8, 4'd2, 4'd6},
        '{4'd2, 4'd3, 4'd0, 4'd5},
        '{4'd3, 4'd7, 4'd4, 4'd6},
        '{4'd1, 4'd6, 4'd0, 4'd7},
        '{4'd0, 4'd4, 4'd1, 4'd3}
    };

    // one classified item handed from front to back
    typedef struct packed {
        logic [8:0][63:0] amag;   // adjugate magnitudes
        logic [8:0]       aneg;   // adjugate signs
        logic [96:0]      dmag;   // determinant magnitude, Q49.48
        logic             dneg;
        logic             sing;   // exact determinant is zero
        logic [31:0]      detv;   // rounded, saturated determinant
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    // clamp a magnitude to the 32-bit two's complement range and apply sign
    function automatic logic [31:0] sat_pack(input logic neg, input logic [65:0] mag);
        logic [65:0] lim;
        logic [31:0] m;
        lim = neg ? 66'h0_8000_0000 : 66'h0_7FFF_FFFF;
        m   = (mag > lim) ? lim[31:0] : mag[31:0];
        return neg ? (~m + 32'd1) : m;
    endfunction

endpackage

FILE: hdl/m3inv_front.sv
// ----------------------------------------------------------------------------
// m3inv_front
// minors, determinant and classification of one matrix per cycle while i_en is high
// ----------------------------------------------------------------------------
module m3inv_front import m3inv_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic signed [31:0] i_a [N_ENT],
    output logic               o_valid,
    output t_item              o_item
);

    logic [F_STAGES-1:0] r_v;

    logic signed [63:0] r_prod [2*N_ENT];
    logic signed [31:0] r_r0a [3];
    logic signed [31:0] r_r0b [3];
    logic signed [63:0] r_adj2 [N_ENT];
    logic signed [63:0] r_adj3 [N_ENT];
    logic signed [63:0] r_adj4 [N_ENT];
    logic signed [63:0] r_adj5 [N_ENT];
    logic signed [63:0] r_adj6 [N_ENT];
    logic signed [64:0] r_plo [3];
    logic signed [63:0] r_phi [3];
    logic signed [95:0] r_t [3];
    logic signed [96:0] r_s;
    logic signed [95:0] r_t2;
    logic signed [97:0] r_det;
    logic [8:0][63:0]   r_amag;
    logic [8:0]         r_aneg;
    logic [96:0]        r_dmag;
    logic               r_dneg;
    logic               r_sing;
    t_item              r_item;

    logic [97:0] n_dabs;
    logic [65:0] n_dv;

    assign n_dabs = r_det[97] ? 98'(-r_det) : 98'(r_det);
    assign n_dv   = {1'b0, r_dmag[96:32]} + 66'(r_dmag[31]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[F_STAGES-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // products of the 2x2 minors
            for (int k = 0; k < N_ENT; k++) begin
                r_prod[2*k]   <= i_a[MINOR_IDX[k][0]] * i_a[MINOR_IDX[k][1]];
                r_prod[2*k+1] <= i_a[MINOR_IDX[k][2]] * i_a[MINOR_IDX[k][3]];
            end
            for (int j = 0; j < 3; j++) begin
                r_r0a[j] <= i_a[j];
                r_r0b[j] <= r_r0a[j];
            end
            for (int k = 0; k < N_ENT; k++) begin
                r_adj2[k] <= r_prod[2*k] - r_prod[2*k+1];
                r_adj3[k] <= r_adj2[k];
                r_adj4[k] <= r_adj3[k];
                r_adj5[k] <= r_adj4[k];
                r_adj6[k] <= r_adj5[k];
                r_amag[k] <= r_adj6[k][63] ? 64'(-r_adj6[k]) : 64'(r_adj6[k]);
                r_aneg[k] <= r_adj6[k][63];
            end
            // 64x32 determinant terms split in two partial products
            for (int j = 0; j < 3; j++) begin
                r_plo[j] <= $signed({1'b0, r_adj2[3*j][31:0]}) * r_r0b[j];
                r_phi[j] <= $signed(r_adj2[3*j][63:32]) * r_r0b[j];
                r_t[j]   <= $signed({r_phi[j], 32'h0})
                          + $signed({{31{r_plo[j][64]}}, r_plo[j]});
            end
            r_s    <= $signed({r_t[0][95], r_t[0]}) + $signed({r_t[1][95], r_t[1]});
            r_t2   <= r_t[2];
            r_det  <= $signed({r_s[96], r_s}) + $signed({{2{r_t2[95]}}, r_t2});
            r_dneg <= r_det[97];
            r_dmag <= n_dabs[96:0];
            r_sing <= (r_det == '0);
            r_item.amag <= r_amag;
            r_item.aneg <= r_aneg;
            r_item.dmag <= r_dmag;
            r_item.dneg <= r_dneg;
            r_item.sing <= r_sing;
            r_item.detv <= sat_pack(r_dneg, n_dv);
        end
    end

    assign o_valid = r_v[F_STAGES-1];
    assign o_item  = r_item;

endmodule

FILE: hdl/m3inv_queue.sv
// ----------------------------------------------------------------------------
// m3inv_queue
// small fifo between the classifying front and the dividing back
// ----------------------------------------------------------------------------
module m3inv_queue import m3inv_pkg::*; #(
    parameter int DEPTH = Q_DEPTH
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_item  i_wdata,
    input  logic   i_pop,
    output t_item  o_rdata,
    output t_qstat o_stat
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_item          r_mem [DEPTH];
    logic [AW-1:0]  r_wp;
    logic [AW-1:0]  r_rp;
    logic [CW-1:0]  r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    assign o_rdata      = r_mem[r_rp];
    assign o_stat.full  = (r_cnt == CW'(DEPTH));
    assign o_stat.empty = (r_cnt == '0);

endmodule

FILE: hdl/m3inv_back.sv
// ----------------------------------------------------------------------------
// m3inv_back
// nine pipelined restoring dividers, rounding, saturation, output register
// ----------------------------------------------------------------------------
module m3inv_back import m3inv_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_item       i_item,
    input  logic        i_stall,
    output logic        o_pop,
    output logic        o_valid,
    output logic [31:0] o_inv [N_ENT],
    output logic [31:0] o_det_value,
    output logic        o_singular
);

    localparam int NS = QBITS;

    logic [NS:0]       r_bv;
    logic              r_ov;
    logic [96:0]       r_rem  [NS+1][N_ENT];
    logic [QBITS-1:0]  r_q    [NS+1][N_ENT];
    logic [8:0]        r_sat  [NS+1];
    logic [8:0]        r_zero [NS+1];
    logic [8:0]        r_neg  [NS+1];
    logic [96:0]       r_den  [NS+1];
    logic              r_sing [NS+1];
    logic [31:0]       r_detv [NS+1];
    logic [8:0]        r_b0;
    logic [31:0]       r_inv  [N_ENT];
    logic [31:0]       r_det_o;
    logic              r_sing_o;

    logic [97:0] w_rem2 [NS+1][N_ENT];
    logic        w_ge   [NS+1][N_ENT];
    logic [97:0] w_diff [NS+1][N_ENT];
    logic        w_rnd  [N_ENT];
    logic [33:0] w_qr   [N_ENT];
    logic [65:0] w_mag  [N_ENT];
    logic        en;

    assign en    = !(r_ov && i_stall);
    assign o_pop = en && i_valid;

    always_comb begin
        for (int s = 0; s <= NS; s++) begin
            for (int k = 0; k < N_ENT; k++) begin
                w_rem2[s][k] = '0;
                w_ge[s][k]   = 1'b0;
                w_diff[s][k] = '0;
            end
        end
        // one quotient bit per stage; only the first step brings in a numerator bit
        for (int s = 1; s <= NS; s++) begin
            for (int k = 0; k < N_ENT; k++) begin
                w_rem2[s][k] = {r_rem[s-1][k], (s == 1) ? r_b0[k] : 1'b0};
                w_ge[s][k]   = w_rem2[s][k] >= {1'b0, r_den[s-1]};
                w_diff[s][k] = w_rem2[s][k] - {1'b0, r_den[s-1]};
            end
        end
        for (int k = 0; k < N_ENT; k++) begin
            w_rnd[k] = {r_rem[NS][k], 1'b0} >= {1'b0, r_den[NS]};
            w_qr[k]  = {1'b0, r_q[NS][k]} + 34'(w_rnd[k]);
            w_mag[k] = r_sat[NS][k] ? '1 : 66'(w_qr[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bv <= '0;
            r_ov <= 1'b0;
        end else if (en) begin
            r_bv <= {r_bv[NS-1:0], i_valid};
            r_ov <= r_bv[NS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            // load: partial remainder is the numerator above the quotient bits
            for (int k = 0; k < N_ENT; k++) begin
                r_rem[0][k]  <= 97'(i_item.amag[k][63:1]);
                r_q[0][k]    <= '0;
                r_sat[0][k]  <= i_item.amag[k][63:1] >= i_item.dmag;
                r_zero[0][k] <= (i_item.amag[k] == '0);
                r_neg[0][k]  <= i_item.aneg[k] ^ i_item.dneg;
                r_b0[k]      <= i_item.amag[k][0];
            end
            r_den[0]  <= i_item.dmag;
            r_sing[0] <= i_item.sing;
            r_detv[0] <= i_item.detv;
            for (int s = 1; s <= NS; s++) begin
                for (int k = 0; k < N_ENT; k++) begin
                    r_rem[s][k] <= w_ge[s][k] ? w_diff[s][k][96:0] : w_rem2[s][k][96:0];
                    r_q[s][k]   <= {r_q[s-1][k][QBITS-2:0], w_ge[s][k]};
                end
                r_sat[s]  <= r_sat[s-1];
                r_zero[s] <= r_zero[s-1];
                r_neg[s]  <= r_neg[s-1];
                r_den[s]  <= r_den[s-1];
                r_sing[s] <= r_sing[s-1];
                r_detv[s] <= r_detv[s-1];
            end
            for (int k = 0; k < N_ENT; k++) begin
                r_inv[k] <= (r_sing[NS] || r_zero[NS][k]) ? '0
                          : sat_pack(r_neg[NS][k], w_mag[k]);
            end
            r_det_o  <= r_sing[NS] ? '0 : r_detv[NS];
            r_sing_o <= r_sing[NS];
        end
    end

    assign o_valid     = r_ov;
    assign o_inv       = r_inv;
    assign o_det_value = r_det_o;
    assign o_singular  = r_sing_o;

endmodule

FILE: hdl/matrix3x3_inverse_unit.sv
// throughput: one matrix per cycle while no stall holds the flow; 8 front stages, queue, 35 back stages
// the 33-stage restoring divider array sets the length of the back pipeline
// reset: synchronous, active low; clears all valid bits and the queue
// a full queue stalls the input; a stalled output freezes only the back part
// ----------------------------------------------------------------------------
// matrix3x3_inverse_unit
// 3x3 Q16.16 matrix inverse by adjugate with determinant and singular flag
// ----------------------------------------------------------------------------
module matrix3x3_inverse_unit import m3inv_pkg::*; #(
    parameter int QUEUE_DEPTH = Q_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input channel
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_a00,
    input  logic signed [31:0] i_a01,
    input  logic signed [31:0] i_a02,
    input  logic signed [31:0] i_a10,
    input  logic signed [31:0] i_a11,
    input  logic signed [31:0] i_a12,
    input  logic signed [31:0] i_a20,
    input  logic signed [31:0] i_a21,
    input  logic signed [31:0] i_a22,
    // output channel
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_inv00,
    output logic signed [31:0] o_inv01,
    output logic signed [31:0] o_inv02,
    output logic signed [31:0] o_inv10,
    output logic signed [31:0] o_inv11,
    output logic signed [31:0] o_inv12,
    output logic signed [31:0] o_inv20,
    output logic signed [31:0] o_inv21,
    output logic signed [31:0] o_inv22,
    output logic signed [31:0] o_det_value,
    output logic               o_singular
);

    // matrix entries in row-major order
    logic signed [31:0] a [N_ENT];
    logic [31:0]        inv [N_ENT];

    // front to queue
    logic   f_valid;
    t_item  f_item;
    logic   front_en;
    logic   push;

    // queue to back
    t_item  q_item;
    t_qstat q_stat;
    logic   pop;

    assign a[0] = i_a00;
    assign a[1] = i_a01;
    assign a[2] = i_a02;
    assign a[3] = i_a10;
    assign a[4] = i_a11;
    assign a[5] = i_a12;
    assign a[6] = i_a20;
    assign a[7] = i_a21;
    assign a[8] = i_a22;

    // the whole front holds while the queue cannot take its last stage
    assign front_en = !q_stat.full;
    assign o_stall  = q_stat.full;
    assign push     = f_valid && front_en;

    m3inv_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (front_en),
        .i_valid (i_valid),
        .i_a     (a),
        .o_valid (f_valid),
        .o_item  (f_item)
    );

    m3inv_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (f_item),
        .i_pop   (pop),
        .o_rdata (q_item),
        .o_stat  (q_stat)
    );

    // back drains the queue one transfer per cycle unless its output waits
    m3inv_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (!q_stat.empty),
        .i_item      (q_item),
        .i_stall     (i_stall),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .o_inv       (inv),
        .o_det_value (o_det_value),
        .o_singular  (o_singular)
    );

    assign o_inv00 = inv[0];
    assign o_inv01 = inv[1];
    assign o_inv02 = inv[2];
    assign o_inv10 = inv[3];
    assign o_inv11 = inv[4];
    assign o_inv12 = inv[5];
    assign o_inv20 = inv[6];
    assign o_inv21 = inv[7];
    assign o_inv22 = inv[8];

endmodule

FILE: hdl/m3inv_checker.sv
// ----------------------------------------------------------------------------
// m3inv_checker
// port-level checks for the 3x3 inverse unit
// ----------------------------------------------------------------------------
module m3inv_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_stall,
    input logic               o_valid,
    input logic               i_stall,
    input logic signed [31:0] o_inv00,
    input logic signed [31:0] o_inv01,
    input logic signed [31:0] o_inv02,
    input logic signed [31:0] o_inv10,
    input logic signed [31:0] o_inv11,
    input logic signed [31:0] o_inv12,
    input logic signed [31:0] o_inv20,
    input logic signed [31:0] o_inv21,
    input logic signed [31:0] o_inv22,
    input logic signed [31:0] o_det_value,
    input logic               o_singular
);

    // a stalled result stays put: determinant, singular flag and the diagonal entries
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_det_value) && $stable(o_singular)
            && $stable(o_inv00) && $stable(o_inv11) && $stable(o_inv22))
        else $error("stalled result changed");

    // a singular matrix gives all-zero entries and determinant
    a_singular_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_singular |-> o_det_value == 0
            && o_inv00 == 0 && o_inv01 == 0 && o_inv02 == 0
            && o_inv10 == 0 && o_inv11 == 0 && o_inv12 == 0
            && o_inv20 == 0 && o_inv21 == 0 && o_inv22 == 0)
        else $error("singular result with nonzero entries");

    // reset empties the pipeline
    a_reset_valid: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // reset empties the queue, so the input is open
    a_reset_stall: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_stall)
        else $error("input stalled right after reset");

endmodule

bind matrix3x3_inverse_unit m3inv_checker u_m3inv_checker (.*);
